[sv/u8u16_pkg.sv]
// u8u16_pkg: shared constants and types of the utf-8 to utf-16 decoder
// used by u8u16_core, u8u16_emit and utf8_to_utf16_decoder; no dependencies
`default_nettype none

package u8u16_pkg;

  // lead byte class boundaries
  localparam logic [7:0] LeadE0 = 8'hE0;
  localparam logic [7:0] LeadF0 = 8'hF0;
  localparam logic [7:0] LeadF8 = 8'hF8;
  localparam logic [7:0] LeadFc = 8'hFC;

  // top two bits of a continuation byte
  localparam logic [1:0] ContTag = 2'b10;

  // code point limits
  localparam logic [31:0] SurrBase = 32'h0001_0000;
  localparam logic [31:0] MaxCode  = 32'h0010_FFFF;

  // high bits of the surrogate halves (0xd800 and 0xdc00)
  localparam logic [5:0] HiSurrTag = 6'b110110;
  localparam logic [5:0] LoSurrTag = 6'b110111;

  // width of the pending continuation count
  localparam int unsigned RemW = 3;

  // up to two results caused by one input byte
  typedef struct packed {
    logic        has;        // at least one result
    logic        pair;       // two results: surrogate pair
    logic        unit_valid; // zero for a bare end marker
    logic        eos;        // final result closes the string
    logic        err;        // decoding stopped on an error
    logic [15:0] unit0;
    logic [15:0] unit1;
  } u8u16_bundle_t;

endpackage

`default_nettype wire

[sv/u8u16_in_if.sv]
// u8u16_in_if: byte request channel of the decoder
// standalone, no package needed
`default_nettype none

interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[sv/u8u16_out_if.sv]
// u8u16_out_if: code unit request channel of the decoder
// standalone, no package needed
`default_nettype none

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        last_of_item;
  logic        end_of_string;
  logic        decode_error;

  modport source (output valid, output code_unit, output unit_valid, output last_of_item,
                  output end_of_string, output decode_error, input ready);
  modport sink   (input valid, input code_unit, input unit_valid, input last_of_item,
                  input end_of_string, input decode_error, output ready);
endinterface

`default_nettype wire

[sv/u8u16_core.sv]
// u8u16_core: input register, sequence state and per-byte decode
// depends on u8u16_pkg and u8u16_in_if
`default_nettype none

module u8u16_core import u8u16_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  u8u16_in_if.sink      req_i,
  output u8u16_bundle_t bnd_o,
  output logic          bnd_valid_o,
  input  wire logic     bnd_ready_i
);

  logic            a_vld_q;
  logic [7:0]      a_byte_q;
  logic            a_last_q;
  logic [31:0]     acc_q, acc_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic            halt_q, halt_d;
  logic            adv;
  u8u16_bundle_t   bnd;

  always_comb begin
    logic        flush;
    logic        ascii;
    logic        below_pair;
    logic        over;
    logic        has_unit;
    logic [31:0] val;
    logic [20:0] sub;

    acc_d  = acc_q;
    rem_d  = rem_q;
    halt_d = halt_q;
    flush  = 1'b0;
    ascii  = 1'b0;
    val    = acc_q;

    if (halt_q) begin
      // dropping bytes until the end of the string
    end else if (rem_q != '0) begin
      if (a_byte_q[7:6] == ContTag) begin
        val   = {acc_q[25:0], a_byte_q[5:0]};
        acc_d = val;
        rem_d = rem_q - RemW'(1);
        flush = (rem_q == RemW'(1)) || a_last_q;
      end else begin
        // sequence cut short, offending byte dropped
        flush = 1'b1;
      end
    end else if (!a_byte_q[7]) begin
      ascii = 1'b1;
    end else if (!a_byte_q[6]) begin
      // stray continuation byte
      halt_d = 1'b1;
    end else begin
      if (a_byte_q < LeadE0) begin
        rem_d = RemW'(1);
        acc_d = {27'd0, a_byte_q[4:0]};
      end else if (a_byte_q < LeadF0) begin
        rem_d = RemW'(2);
        acc_d = {28'd0, a_byte_q[3:0]};
      end else if (a_byte_q < LeadF8) begin
        rem_d = RemW'(3);
        acc_d = {29'd0, a_byte_q[2:0]};
      end else if (a_byte_q < LeadFc) begin
        rem_d = RemW'(4);
        acc_d = {30'd0, a_byte_q[1:0]};
      end else begin
        rem_d = RemW'(5);
        acc_d = {30'd0, a_byte_q[1:0]};
      end
      val   = acc_d;
      flush = a_last_q;
    end

    below_pair = (val < SurrBase);
    over       = (val > MaxCode);
    sub        = val[20:0] - SurrBase[20:0];

    if (flush) begin
      acc_d = '0;
      rem_d = '0;
      if (over) begin
        halt_d = 1'b1;
      end
    end

    has_unit = ascii || (flush && !over);

    bnd            = '0;
    bnd.unit1      = {LoSurrTag, sub[9:0]};
    if (ascii) begin
      bnd.unit0 = {8'd0, a_byte_q};
    end else if (below_pair) begin
      bnd.unit0 = val[15:0];
    end else begin
      bnd.unit0 = {HiSurrTag, sub[19:10]};
    end

    if (a_last_q && (halt_d || !has_unit)) begin
      // bare end marker
      bnd.has        = 1'b1;
      bnd.pair       = 1'b0;
      bnd.unit_valid = 1'b0;
      bnd.eos        = 1'b1;
      bnd.err        = halt_d;
      bnd.unit0      = '0;
    end else begin
      bnd.has        = has_unit;
      bnd.pair       = flush && !below_pair && !over;
      bnd.unit_valid = 1'b1;
      bnd.eos        = a_last_q;
      bnd.err        = 1'b0;
    end

    if (a_last_q) begin
      acc_d  = '0;
      rem_d  = '0;
      halt_d = 1'b0;
    end
  end

  assign adv         = a_vld_q && (!bnd.has || bnd_ready_i);
  assign bnd_o       = bnd;
  assign bnd_valid_o = a_vld_q && bnd.has;
  assign req_i.ready = !a_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      acc_q   <= '0;
      rem_q   <= '0;
      halt_q  <= 1'b0;
    end else begin
      if (req_i.ready) begin
        a_vld_q <= req_i.valid;
      end
      if (adv) begin
        acc_q  <= acc_d;
        rem_q  <= rem_d;
        halt_q <= halt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      a_byte_q <= req_i.data_byte;
      a_last_q <= req_i.last_byte;
    end
  end

endmodule

`default_nettype wire

[sv/u8u16_emit.sv]
// u8u16_emit: result register that hands out one or two code units per byte
// depends on u8u16_pkg and u8u16_out_if
`default_nettype none

module u8u16_emit import u8u16_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire u8u16_bundle_t  bnd_i,
  input  wire logic           bnd_valid_i,
  output logic                bnd_ready_o,
  u8u16_out_if.source         res_o
);

  u8u16_bundle_t b_q;
  logic          b_vld_q;
  logic          second_q;
  logic          fin;
  logic          pop;

  // final entry of the bundle: a single result or the second half of a pair
  assign fin         = !b_q.pair || second_q;
  assign pop         = b_vld_q && res_o.ready && fin;
  assign bnd_ready_o = !b_vld_q || pop;

  assign res_o.valid         = b_vld_q;
  assign res_o.code_unit     = second_q ? b_q.unit1 : b_q.unit0;
  assign res_o.unit_valid    = b_q.unit_valid;
  assign res_o.last_of_item  = fin;
  assign res_o.end_of_string = b_q.eos && fin;
  assign res_o.decode_error  = b_q.err && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      if (bnd_ready_o) begin
        b_vld_q  <= bnd_valid_i;
        second_q <= 1'b0;
      end else if (res_o.ready) begin
        // first half of a pair taken
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_ready_o && bnd_valid_i) begin
      b_q <= bnd_i;
    end
  end

endmodule

`default_nettype wire

[sv/utf8_to_utf16_decoder.sv]
// utf8_to_utf16_decoder: streaming utf-8 to utf-16 decoder, top level
// depends on u8u16_pkg, u8u16_in_if, u8u16_out_if, u8u16_core and u8u16_emit
//
// usage
//   req_i takes one byte of a utf-8 string per request, last_byte marks the
//   final byte of the string. res_o gives utf-16 code units, one per request,
//   with last_of_item on the final result of each byte and end_of_string on
//   the final result of the string; a string that yields no unit, or that
//   stopped on an error, ends with a bare marker (unit_valid low)
// timing
//   a byte taken into the input register is decoded out of it and moves into
//   the result register, from which its first result is offered; it waits in
//   the input register while the result register is full
//   one byte per cycle while res_o accepts; a byte that completes a surrogate
//   pair holds the result register until both halves pass the single port
// reset
//   clears the pipeline valids and the sequence state; no clearing pass
// back-pressure
//   when res_o stalls the result register holds, the decoded byte waits in
//   the input register and req_i.ready drops once both are occupied
`default_nettype none

module utf8_to_utf16_decoder import u8u16_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  u8u16_in_if.sink  req_i,
  u8u16_out_if.source res_o
);

  // bundle of up to two results between decode and the result register
  u8u16_bundle_t bnd;
  logic          bnd_valid;
  logic          bnd_ready;

  // input register, sequence state and decode
  u8u16_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .bnd_o       (bnd),
    .bnd_valid_o (bnd_valid),
    .bnd_ready_i (bnd_ready)
  );

  // result register and pair serialiser
  u8u16_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bnd_i       (bnd),
    .bnd_valid_i (bnd_valid),
    .bnd_ready_o (bnd_ready),
    .res_o       (res_o)
  );

  // a decoded byte held back by a full result register must not change
  a_bnd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_valid && !bnd_ready |=> bnd_valid && $stable(bnd))
    else $error("decoded bundle changed while stalled");

  // an error is only ever reported on a bare end marker
  a_err_bare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.decode_error |-> !res_o.unit_valid && res_o.end_of_string)
    else $error("decode error on a non-marker result");

  // the low surrogate follows its high half straight away
  a_pair_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && !res_o.last_of_item |=>
      res_o.valid && res_o.unit_valid && res_o.last_of_item)
    else $error("second half of surrogate pair missing");

endmodule

`default_nettype wire
